[rtl/core/minimum_covering_window_search_unit_defines.svh]
// Assertion macros shared by the minimum covering window search unit.
`ifndef MINIMUM_COVERING_WINDOW_SEARCH_UNIT_DEFINES_SVH
`define MINIMUM_COVERING_WINDOW_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MCWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mcws_pkg.sv]
// Package with types, constants and helpers of the minimum covering window search unit.
`timescale 1ns / 1ps

package mcws_pkg;

    localparam int TEXT_CAPACITY    = 4096;
    localparam int ALPHABET_SIZE    = 256;
    localparam int PATTERN_CAPACITY = 4096;

    localparam int SYM_W        = 8;
    localparam int BAL_W        = 14;
    localparam int TEXT_ADDR_W  = $clog2(TEXT_CAPACITY);
    localparam int TEXT_CNT_W   = $clog2(TEXT_CAPACITY + 1);
    localparam int PAT_CNT_W    = $clog2(PATTERN_CAPACITY + 1);
    localparam int ALPHA_ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_FINISH  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [SYM_W-1:0] symbol;
    } mcws_cmd_t;

    typedef struct packed {
        logic        found;
        logic [11:0] window_begin;
        logic [12:0] window_length;
        logic        text_overflow;
    } mcws_rpt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT_UPD,
        ST_TXT_UPD,
        ST_SHRINK_CHK,
        ST_SHRINK_TXT,
        ST_SHRINK_BAL
    } mcws_state_t;

    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } mcws_alu_op_t;

    typedef struct packed {
        logic                    clear;
        logic                    rd_en;
        logic [ALPHA_ADDR_W-1:0] rd_addr;
        logic                    wr_en;
        logic [ALPHA_ADDR_W-1:0] wr_addr;
        logic [BAL_W-1:0]        wr_data;
    } mcws_bal_ctl_t;

    typedef struct packed {
        logic                   wr_en;
        logic [TEXT_ADDR_W-1:0] wr_addr;
        logic [SYM_W-1:0]       wr_data;
        logic                   rd_en;
        logic [TEXT_ADDR_W-1:0] rd_addr;
    } mcws_txt_ctl_t;

    typedef struct packed {
        logic [BAL_W-1:0] result;
        logic             was_pos;
        logic             now_pos;
    } mcws_alu_res_t;

    function automatic logic sym_in_alphabet(input logic [SYM_W-1:0] s);
        return {1'b0, s} < (SYM_W + 1)'(ALPHABET_SIZE);
    endfunction

endpackage

[rtl/core/mcws_alu.sv]
// Shared balance unit: increments or decrements one signed symbol balance.
`timescale 1ns / 1ps

module mcws_alu (
    input  logic [mcws_pkg::BAL_W-1:0] operand,
    input  mcws_pkg::mcws_alu_op_t     op,
    output mcws_pkg::mcws_alu_res_t    res
);
    import mcws_pkg::*;

    logic [BAL_W-1:0] sum;

    always_comb
    begin
        if (op == ALU_INC)
        begin
            sum = operand + BAL_W'(1);
        end
        else
        begin
            sum = operand - BAL_W'(1);
        end
        res.result  = sum;
        // Positive means sign bit clear and not zero.
        res.was_pos = !operand[BAL_W-1] && (operand != '0);
        res.now_pos = !sum[BAL_W-1] && (sum != '0);
    end

endmodule

[rtl/core/mcws_balance_mem.sv]
// Symbol balance table: single-port memory with per-entry valid bits for instant clearing.
`timescale 1ns / 1ps

module mcws_balance_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcws_pkg::mcws_bal_ctl_t    ctl,
    output logic [mcws_pkg::BAL_W-1:0] rd_data
);
    import mcws_pkg::*;

    logic [BAL_W-1:0]         mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic [BAL_W-1:0]         data_reg;
    logic                     hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                hit_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = hit_reg ? data_reg : '0;

endmodule

[rtl/core/mcws_text_mem.sv]
// Text store: single-port byte memory with registered read data.
`timescale 1ns / 1ps

module mcws_text_mem (
    input  logic                       clk,
    input  mcws_pkg::mcws_txt_ctl_t    ctl,
    output logic [mcws_pkg::SYM_W-1:0] rd_data
);
    import mcws_pkg::*;

    logic [SYM_W-1:0] mem [TEXT_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr];
        end
    end

endmodule

[rtl/core/minimum_covering_window_search_unit.sv]
// Top level of the minimum covering window search unit: sequencer, counters and report.
//
//  Channel | Direction | Word       | Handshake
//  --------+-----------+------------+-----------------------
//  cmd     | in        | mcws_cmd_t | cmd_valid / cmd_ready
//  rpt     | out       | mcws_rpt_t | rpt_valid / rpt_ready
//
// A pattern byte passes through ST_PAT_UPD; a finish word or dropped text byte stays in idle.
// A stored text byte passes through ST_TXT_UPD (not when outside the alphabet), ST_SHRINK_CHK,
// and ST_SHRINK_TXT and ST_SHRINK_BAL for every position the window shrinks by; the single-port
// balance table and its registered read set these steps, one read-modify-write per symbol.
// Reset clears all counters and the balance valid bits at once; there is no clearing pass.
// cmd_ready is low while a word is being worked on, and also while a report waits.
`timescale 1ns / 1ps
`include "minimum_covering_window_search_unit_defines.svh"

module minimum_covering_window_search_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mcws_pkg::mcws_cmd_t cmd_word,
    output logic                rpt_valid,
    input  logic                rpt_ready,
    output mcws_pkg::mcws_rpt_t rpt_word
);
    import mcws_pkg::*;

    mcws_state_t state_reg, state_next;

    logic [TEXT_CNT_W-1:0]  text_count_reg, text_count_next;
    logic [TEXT_CNT_W-1:0]  left_edge_reg, left_edge_next;
    logic [PAT_CNT_W-1:0]   covered_reg, covered_next;
    logic [PAT_CNT_W-1:0]   pattern_count_reg, pattern_count_next;
    logic [TEXT_ADDR_W-1:0] best_begin_reg, best_begin_next;
    logic [TEXT_CNT_W-1:0]  best_length_reg, best_length_next;
    logic                   overflow_reg, overflow_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic                   rpt_valid_reg, rpt_valid_next;
    mcws_rpt_t              rpt_reg, rpt_next;

    mcws_bal_ctl_t    bal_ctl;
    mcws_txt_ctl_t    txt_ctl;
    logic [BAL_W-1:0] bal_rd_data;
    logic [SYM_W-1:0] txt_rd_data;
    mcws_alu_op_t     alu_op;
    mcws_alu_res_t    alu_res;

    logic                  cmd_fire;
    logic [TEXT_CNT_W-1:0] win_len;
    logic                  found;

    mcws_balance_mem u_bal (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bal_ctl),
        .rd_data (bal_rd_data)
    );

    mcws_text_mem u_txt (
        .clk     (clk),
        .ctl     (txt_ctl),
        .rd_data (txt_rd_data)
    );

    mcws_alu u_alu (
        .operand (bal_rd_data),
        .op      (alu_op),
        .res     (alu_res)
    );

    // A new word is taken only when idle and when no earlier report would be overwritten.
    assign cmd_ready = (state_reg == ST_IDLE) && (!rpt_valid_reg || rpt_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign win_len   = text_count_reg - left_edge_reg;
    assign found     = (best_length_reg != '0);

    assign rpt_valid = rpt_valid_reg;
    assign rpt_word  = rpt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            text_count_reg    <= '0;
            left_edge_reg     <= '0;
            covered_reg       <= '0;
            pattern_count_reg <= '0;
            best_begin_reg    <= '0;
            best_length_reg   <= '0;
            overflow_reg      <= 1'b0;
            rpt_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            text_count_reg    <= text_count_next;
            left_edge_reg     <= left_edge_next;
            covered_reg       <= covered_next;
            pattern_count_reg <= pattern_count_next;
            best_begin_reg    <= best_begin_next;
            best_length_reg   <= best_length_next;
            overflow_reg      <= overflow_next;
            rpt_valid_reg     <= rpt_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        rpt_reg <= rpt_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        text_count_next    = text_count_reg;
        left_edge_next     = left_edge_reg;
        covered_next       = covered_reg;
        pattern_count_next = pattern_count_reg;
        best_begin_next    = best_begin_reg;
        best_length_next   = best_length_reg;
        overflow_next      = overflow_reg;
        sym_next           = sym_reg;
        rpt_valid_next     = rpt_valid_reg;
        rpt_next           = rpt_reg;
        alu_op             = ALU_INC;

        bal_ctl         = '0;
        bal_ctl.wr_addr = sym_reg[ALPHA_ADDR_W-1:0];
        bal_ctl.wr_data = alu_res.result;
        txt_ctl         = '0;

        if (rpt_valid_reg && rpt_ready)
        begin
            rpt_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd_word.action)
                        ACT_PATTERN:
                        begin
                            // Pattern bytes count only before any text and within capacity.
                            if ((text_count_reg == '0) &&
                                (pattern_count_reg < PAT_CNT_W'(PATTERN_CAPACITY)) &&
                                sym_in_alphabet(cmd_word.symbol))
                            begin
                                bal_ctl.rd_en   = 1'b1;
                                bal_ctl.rd_addr = cmd_word.symbol[ALPHA_ADDR_W-1:0];
                                sym_next        = cmd_word.symbol;
                                state_next      = ST_PAT_UPD;
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (text_count_reg >= TEXT_CNT_W'(TEXT_CAPACITY))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                txt_ctl.wr_en   = 1'b1;
                                txt_ctl.wr_addr = text_count_reg[TEXT_ADDR_W-1:0];
                                txt_ctl.wr_data = cmd_word.symbol;
                                text_count_next = text_count_reg + TEXT_CNT_W'(1);
                                sym_next        = cmd_word.symbol;
                                if (sym_in_alphabet(cmd_word.symbol))
                                begin
                                    bal_ctl.rd_en   = 1'b1;
                                    bal_ctl.rd_addr = cmd_word.symbol[ALPHA_ADDR_W-1:0];
                                    state_next      = ST_TXT_UPD;
                                end
                                else
                                begin
                                    state_next = ST_SHRINK_CHK;
                                end
                            end
                        end
                        ACT_FINISH:
                        begin
                            rpt_next.found         = found;
                            rpt_next.window_begin  = found ? 12'(best_begin_reg) : 12'd0;
                            rpt_next.window_length = found ? 13'(best_length_reg) : 13'd0;
                            rpt_next.text_overflow = overflow_reg;
                            rpt_valid_next         = 1'b1;
                            bal_ctl.clear          = 1'b1;
                            text_count_next        = '0;
                            left_edge_next         = '0;
                            covered_next           = '0;
                            pattern_count_next     = '0;
                            best_begin_next        = '0;
                            best_length_next       = '0;
                            overflow_next          = 1'b0;
                        end
                        default:
                        begin
                            // The unused action code is dropped without a report.
                        end
                    endcase
                end
            end
            ST_PAT_UPD:
            begin
                alu_op             = ALU_INC;
                bal_ctl.wr_en      = 1'b1;
                pattern_count_next = pattern_count_reg + PAT_CNT_W'(1);
                state_next         = ST_IDLE;
            end
            ST_TXT_UPD:
            begin
                alu_op        = ALU_DEC;
                bal_ctl.wr_en = 1'b1;
                if (alu_res.was_pos)
                begin
                    covered_next = covered_reg + PAT_CNT_W'(1);
                end
                state_next = ST_SHRINK_CHK;
            end
            ST_SHRINK_CHK:
            begin
                if ((pattern_count_reg != '0) && (covered_reg == pattern_count_reg) &&
                    (left_edge_reg < text_count_reg))
                begin
                    if ((best_length_reg == '0) || (win_len < best_length_reg))
                    begin
                        best_length_next = win_len;
                        best_begin_next  = left_edge_reg[TEXT_ADDR_W-1:0];
                    end
                    txt_ctl.rd_en   = 1'b1;
                    txt_ctl.rd_addr = left_edge_reg[TEXT_ADDR_W-1:0];
                    state_next      = ST_SHRINK_TXT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHRINK_TXT:
            begin
                sym_next = txt_rd_data;
                if (sym_in_alphabet(txt_rd_data))
                begin
                    bal_ctl.rd_en   = 1'b1;
                    bal_ctl.rd_addr = txt_rd_data[ALPHA_ADDR_W-1:0];
                    state_next      = ST_SHRINK_BAL;
                end
                else
                begin
                    left_edge_next = left_edge_reg + TEXT_CNT_W'(1);
                    state_next     = ST_SHRINK_CHK;
                end
            end
            ST_SHRINK_BAL:
            begin
                alu_op        = ALU_INC;
                bal_ctl.wr_en = 1'b1;
                if (alu_res.now_pos)
                begin
                    covered_next = covered_reg - PAT_CNT_W'(1);
                end
                left_edge_next = left_edge_reg + TEXT_CNT_W'(1);
                state_next     = ST_SHRINK_CHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The block takes words only from the idle state.
    `MCWS_ASSERT_NOW(a_ready_idle, clk, rst_n, cmd_ready, state_reg == ST_IDLE, "ready outside idle")
    // Covered bytes never exceed the pattern size.
    `MCWS_ASSERT_NOW(a_cover_bound, clk, rst_n, 1'b1, covered_reg <= pattern_count_reg, "covered count above pattern count")
    // The left edge never passes the end of the stored text.
    `MCWS_ASSERT_NOW(a_left_bound, clk, rst_n, 1'b1, left_edge_reg <= text_count_reg, "left edge beyond text")
    // A finish word raises a report and leaves the state cleared.
    `MCWS_ASSERT_NEXT(a_finish_clear, clk, rst_n, cmd_fire && (cmd_word.action == ACT_FINISH), rpt_valid_reg && (text_count_reg == '0) && (pattern_count_reg == '0), "finish did not report and clear")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the minimum covering window search unit.
`timescale 1ns / 1ps

module testbench;

    import mcws_pkg::*;

    // The two-bit action field has one code that the block does not use; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Number of useful command words in the random part, and the point after which all idling
    // stops so that the last stretch of the run goes at full rate on both channels.
    localparam int unsigned RANDOM_WORDS = 1450;
    localparam int unsigned QUIET_FROM   = 1150;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    mcws_cmd_t  cmd_word;
    logic       rpt_valid;
    logic       rpt_ready;
    mcws_rpt_t  rpt_word;

    // Set while random idling bursts are allowed on the command and report channels.
    bit         bursts_on;

    // Reports worked out from accepted finish words, oldest first.
    mcws_rpt_t  pending_reports [$];
    mcws_rpt_t  oldest_report;
    int unsigned mismatch_count;

    // Predicted contents of the block. The balance table counts pattern bytes still owed by the
    // current window for each symbol. It goes negative when the window holds surplus copies.
    logic signed [BAL_W-1:0]      balance_tbl [ALPHABET_SIZE];
    logic [SYM_W-1:0]             text_mem [TEXT_CAPACITY];
    logic [TEXT_CNT_W-1:0]        seen_text;
    logic [TEXT_CNT_W-1:0]        left_pos;
    logic [PAT_CNT_W-1:0]         covered;
    logic [PAT_CNT_W-1:0]         pat_total;
    logic [TEXT_ADDR_W-1:0]       best_pos;
    logic [TEXT_CNT_W-1:0]        best_span;
    logic                         dropped_text;

    minimum_covering_window_search_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt_word  (rpt_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous overall limit; the slowest correct run stays well below it.
    initial
    begin
        #10_000_000;
        $display("minimum_covering_window_search_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------------------------

    // Returns the predicted block to its empty state, as after reset or after a finish word.
    task automatic clear_window_state();
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            balance_tbl[i] = '0;
        end
        seen_text    = '0;
        left_pos     = '0;
        covered      = '0;
        pat_total    = '0;
        best_pos     = '0;
        best_span    = '0;
        dropped_text = 1'b0;
    endtask

    // Applies one accepted command word to the predicted state. A finish word queues the report
    // that the block must return. With a full byte alphabet every symbol touches the balances.
    task automatic advance_window(input logic [1:0] act, input logic [SYM_W-1:0] sym);
        logic [TEXT_CNT_W-1:0] span;
        logic [SYM_W-1:0]      leaving;
        mcws_rpt_t             rpt;
        case (act)
            ACT_PATTERN:
            begin
                // Pattern bytes count only before the first text byte and up to capacity.
                if (seen_text == '0 && pat_total < PAT_CNT_W'(PATTERN_CAPACITY))
                begin
                    balance_tbl[sym] = balance_tbl[sym] + BAL_W'(1);
                    pat_total        = pat_total + PAT_CNT_W'(1);
                end
            end
            ACT_TEXT:
            begin
                if (seen_text >= TEXT_CNT_W'(TEXT_CAPACITY))
                begin
                    dropped_text = 1'b1;
                end
                else
                begin
                    text_mem[seen_text[TEXT_ADDR_W-1:0]] = sym;
                    seen_text = seen_text + TEXT_CNT_W'(1);
                    if (balance_tbl[sym] > 0)
                    begin
                        covered = covered + PAT_CNT_W'(1);
                    end
                    balance_tbl[sym] = balance_tbl[sym] - BAL_W'(1);
                    // While the window covers the whole pattern, note it if it is the shortest
                    // yet and give up its leftmost byte.
                    while (pat_total != '0 && covered == pat_total && left_pos < seen_text)
                    begin
                        span = seen_text - left_pos;
                        if (best_span == '0 || span < best_span)
                        begin
                            best_span = span;
                            best_pos  = left_pos[TEXT_ADDR_W-1:0];
                        end
                        leaving = text_mem[left_pos[TEXT_ADDR_W-1:0]];
                        balance_tbl[leaving] = balance_tbl[leaving] + BAL_W'(1);
                        if (balance_tbl[leaving] > 0)
                        begin
                            covered = covered - PAT_CNT_W'(1);
                        end
                        left_pos = left_pos + TEXT_CNT_W'(1);
                    end
                end
            end
            ACT_FINISH:
            begin
                rpt.found         = (best_span != '0);
                rpt.window_begin  = rpt.found ? best_pos : '0;
                rpt.window_length = rpt.found ? best_span : '0;
                rpt.text_overflow = dropped_text;
                pending_reports.push_back(rpt);
                clear_window_state();
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------------------------

    // Offers one command word and returns at the edge where it is taken. Valid is left high so
    // that back-to-back words need no second assignment in the same step; a gap lowers it first.
    task automatic send_word(input logic [1:0] act, input logic [SYM_W-1:0] sym);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= '{action: act, symbol: sym};
        do
            @(posedge clk);
        while (!cmd_ready);
        advance_window(act, sym);
    endtask

    task automatic send_bytes(input logic [1:0] act, input string bytes_in);
        for (int i = 0; i < bytes_in.len(); i++)
        begin
            send_word(act, bytes_in[i]);
        end
    endtask

    // Lowers valid and waits until every predicted report has come back, then waits on so
    // that a stray extra report would still be seen.
    task automatic drain_reports();
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (32) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------------------------
    // Report channel: random back-pressure and field-by-field checking
    // ------------------------------------------------------------------------------------------

    initial
    begin
        rpt_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (bursts_on && $urandom_range(0, 1) == 0)
            begin
                rpt_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rpt_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rpt_valid && rpt_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report word arrived with none outstanding: %h", rpt_word);
                mismatch_count++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                if (rpt_word.found !== oldest_report.found)
                begin
                    $error("found: expected %0d, got %0d", oldest_report.found, rpt_word.found);
                    mismatch_count++;
                end
                if (rpt_word.window_begin !== oldest_report.window_begin)
                begin
                    $error("window_begin: expected %0d, got %0d",
                           oldest_report.window_begin, rpt_word.window_begin);
                    mismatch_count++;
                end
                if (rpt_word.window_length !== oldest_report.window_length)
                begin
                    $error("window_length: expected %0d, got %0d",
                           oldest_report.window_length, rpt_word.window_length);
                    mismatch_count++;
                end
                if (rpt_word.text_overflow !== oldest_report.text_overflow)
                begin
                    $error("text_overflow: expected %0d, got %0d",
                           oldest_report.text_overflow, rpt_word.text_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------------

    // The textbook case: the shortest window holding A, B and C is "BANC" at position 9.
    task automatic test_known_window();
        send_bytes(ACT_PATTERN, "ABC");
        send_bytes(ACT_TEXT, "ADOBECODEBANC");
        send_word(ACT_FINISH, 8'h00);
    endtask

    // Repeated pattern bytes must all be matched; an empty pattern never finds a window, with
    // or without text behind it.
    task automatic test_missing_and_empty();
        send_bytes(ACT_PATTERN, "AA");
        send_bytes(ACT_TEXT, "BAB");
        send_word(ACT_FINISH, 8'h5A);
        send_word(ACT_FINISH, 8'hFF);
        send_bytes(ACT_TEXT, "XYZ");
        send_word(ACT_FINISH, 8'h01);
    endtask

    // The lowest and highest byte values are ordinary symbols, the top one included.
    task automatic test_byte_extremes();
        send_word(ACT_PATTERN, 8'h00);
        send_word(ACT_PATTERN, 8'hFF);
        send_word(ACT_TEXT, 8'hFF);
        send_word(ACT_TEXT, 8'h80);
        send_word(ACT_TEXT, 8'h7F);
        send_word(ACT_TEXT, 8'h00);
        send_word(ACT_FINISH, 8'hFF);
    endtask

    // A pattern byte after text has begun and a word with the unused action are both ignored.
    task automatic test_late_pattern_and_unused();
        send_bytes(ACT_PATTERN, "x");
        send_bytes(ACT_TEXT, "y");
        send_bytes(ACT_PATTERN, "y");
        send_word(ACT_UNUSED, 8'hA5);
        send_word(ACT_UNUSED, 8'h5A);
        send_bytes(ACT_TEXT, "x");
        send_word(ACT_FINISH, 8'h33);
    endtask

    // Fills the text store. The first set covers it from end to end, so the window length needs
    // its top bit, then overflows it. The second puts the only match on the last position.
    task automatic test_text_overflow();
        send_bytes(ACT_PATTERN, "AB");
        send_word(ACT_TEXT, "A");
        repeat (TEXT_CAPACITY - 2) send_word(ACT_TEXT, "C");
        send_word(ACT_TEXT, "B");
        repeat (4) send_word(ACT_TEXT, "A");
        send_word(ACT_FINISH, 8'h00);
        send_bytes(ACT_PATTERN, "Z");
        repeat (TEXT_CAPACITY - 1) send_word(ACT_TEXT, "Y");
        send_word(ACT_TEXT, "Z");
        send_word(ACT_FINISH, 8'h00);
    endtask

    // A full pattern, then one byte past capacity that must be dropped: if it were kept, the
    // text below could never cover it. One text byte past the store's end follows as well.
    task automatic test_pattern_capacity();
        repeat (PATTERN_CAPACITY) send_word(ACT_PATTERN, "P");
        send_word(ACT_PATTERN, "Q");
        repeat (TEXT_CAPACITY) send_word(ACT_TEXT, "P");
        send_word(ACT_TEXT, "Q");
        send_word(ACT_FINISH, 8'hC3);
    endtask

    // Mostly well-formed sessions over a handful of random byte values, so that windows are
    // found and shrunk often, with occasional long texts, late pattern bytes, unused words and
    // bursts of raw noise. Idling stops for the last stretch.
    task automatic test_random_sessions();
        int unsigned      useful;
        int unsigned      n_letters;
        int unsigned      pat_n;
        int unsigned      txt_n;
        logic [1:0]       act;
        logic [SYM_W-1:0] letters [6];
        useful = 0;
        while (useful < RANDOM_WORDS)
        begin
            bursts_on = (useful < QUIET_FROM);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    act = 2'($urandom_range(0, 3));
                    send_word(act, 8'($urandom));
                    if (act != ACT_UNUSED)
                    begin
                        useful++;
                    end
                end
            end
            else
            begin
                n_letters = $urandom_range(1, 6);
                foreach (letters[k])
                begin
                    letters[k] = 8'($urandom);
                end
                pat_n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
                txt_n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(0, 30);
                for (int j = 0; j < pat_n; j++)
                begin
                    send_word(ACT_PATTERN, letters[$urandom_range(0, n_letters - 1)]);
                end
                for (int j = 0; j < txt_n; j++)
                begin
                    if ($urandom_range(0, 39) == 0)
                    begin
                        send_word(ACT_PATTERN, letters[$urandom_range(0, n_letters - 1)]);
                    end
                    else if ($urandom_range(0, 59) == 0)
                    begin
                        send_word(ACT_UNUSED, 8'($urandom));
                    end
                    send_word(ACT_TEXT, letters[$urandom_range(0, n_letters - 1)]);
                end
                send_word(ACT_FINISH, 8'($urandom));
                useful += pat_n + txt_n + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_word       = '0;
        bursts_on      = 1'b1;
        mismatch_count = 0;
        clear_window_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_window();
        test_missing_and_empty();
        test_byte_extremes();
        test_late_pattern_and_unused();
        test_text_overflow();
        test_pattern_capacity();
        test_random_sessions();
        drain_reports();

        if (mismatch_count == 0)
        begin
            $display("minimum_covering_window_search_unit regression: pass");
        end
        else
        begin
            $display("minimum_covering_window_search_unit regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mcws_pkg.sv
rtl/core/mcws_alu.sv
rtl/core/mcws_balance_mem.sv
rtl/core/mcws_text_mem.sv
rtl/core/minimum_covering_window_search_unit.sv
verif/testbench.sv
